// ----- rtl/core/eabm_pkg.sv -----
package eabm_pkg;

    localparam int PIXEL_BITS   = 16;
    localparam int FW_BITS      = 11;
    localparam int FH_BITS      = 16;
    localparam int ROW_BITS     = FH_BITS + 1;
    localparam int ADDR_BITS    = 3;
    localparam int RS_BITS      = PIXEL_BITS + 2;
    localparam int SUM_BITS     = PIXEL_BITS + 4;
    localparam int DIVISOR_BITS = 4;

    // The divider retires this many quotient bits per cycle.
    localparam int DIV_STEP_BITS = 8;
    localparam int DIV_CYCLES    = (SUM_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DIV_BITS      = DIV_CYCLES * DIV_STEP_BITS;
    localparam int DIV_CNT_BITS  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam int DEFAULT_WIDTH  = 1024;
    localparam int DEFAULT_HEIGHT = 1024;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Register index, taken from bit 2 of the byte address.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic                         cmd;
        logic signed [PIXEL_BITS-1:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] mean_value;
        logic                         end_of_frame;
    } out_item_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic [DIVISOR_BITS-1:0]    divisor;
    } div_req_t;

endpackage

// ----- rtl/core/eabm_div.sv -----
module eabm_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  eabm_pkg::div_req_t                  req,
    output logic                                done,
    output logic signed [eabm_pkg::PIXEL_BITS-1:0] quotient
);
    import eabm_pkg::*;

    logic [DIV_BITS-1:0]     num_reg;
    logic [DIV_BITS-1:0]     num_next;
    logic [DIVISOR_BITS-1:0] rem_reg;
    logic [DIVISOR_BITS-1:0] rem_next;
    logic [DIVISOR_BITS-1:0] dvs_reg;
    logic [DIVISOR_BITS:0]   trial;
    logic [SUM_BITS-1:0]     mag;
    logic [PIXEL_BITS-1:0]   q;
    logic                    neg_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;

    // Division runs on the magnitude so that the quotient truncates toward zero.
    assign mag = req.sum[SUM_BITS-1] ? (SUM_BITS'(~req.sum) + SUM_BITS'(1))
                                     : SUM_BITS'(req.sum);

    // Restoring division; the remainder stays below the divisor, so it is narrow.
    always_comb begin
        num_next = num_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            trial    = {rem_next, num_next[DIV_BITS-1]};
            num_next = {num_next[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next    = DIVISOR_BITS'(trial - {1'b0, dvs_reg});
                num_next[0] = 1'b1;
            end else begin
                rem_next = trial[DIVISOR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(DIV_CYCLES - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_BITS'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= DIV_BITS'(mag);
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            neg_reg <= req.sum[SUM_BITS-1];
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign q        = num_reg[PIXEL_BITS-1:0];
    assign quotient = neg_reg ? (~q + PIXEL_BITS'(1)) : q;
    assign done     = done_reg;

endmodule

// ----- rtl/core/edge_aware_box_mean_3x3.sv -----
// Channel   Ports                          Moves
// input     s_valid, s_ready, s_item       one pixel or drain item
// result    m_valid, m_ready, m_item       one neighborhood mean
// config    psel, penable, pwrite, paddr,  frame_width at 0x0, frame_height at 0x4
//           pwdata, prdata, pready
//
// An item that yields no result only shifts; one that yields a result also passes through
// the row-sum, total, start, divide and push states, the divider retiring 8 quotient bits
// a cycle. A drain item of a single-row frame also reads and shifts an extra blank column.
// Reset clears the control state only; the row stores need no clearing pass.
// A finished result waits in the output register while the next item is taken in;
// the following result holds the input stalled until that register has been taken.
module edge_aware_box_mean_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  eabm_pkg::in_item_t                s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output eabm_pkg::out_item_t               m_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [eabm_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import eabm_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int RESET_WIDTH = (MAX_WIDTH < DEFAULT_WIDTH) ? MAX_WIDTH : DEFAULT_WIDTH;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SHIFT = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_ROWS  = 8'b0000_1000,
        S_TOTAL = 8'b0001_0000,
        S_START = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_PUSH  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [WB-1:0]        width_reg;
    logic [FH_BITS-1:0]   height_reg;
    logic [CB-1:0]        in_col_reg;
    logic [ROW_BITS-1:0]  in_row_reg;
    logic [CB-1:0]        out_col_reg;
    logic [FH_BITS-1:0]   out_row_reg;

    logic [PIXEL_BITS-1:0] row_a_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] row_b_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_a_reg;
    logic [PIXEL_BITS-1:0] rd_b_reg;

    logic signed [PIXEL_BITS-1:0] win_reg [3][3];
    logic [PIXEL_BITS-1:0]        x_reg;
    logic                         drain_reg;
    logic                         retry_reg;
    logic                         top_reg;
    logic                         bottom_reg;
    logic                         left_reg;
    logic                         right_reg;
    logic                         eof_reg;

    logic signed [RS_BITS-1:0]  row_sum [3];
    logic signed [RS_BITS-1:0]  row_sum_reg [3];
    logic signed [SUM_BITS-1:0] sum_reg;
    logic [2:0]                 row_on;
    logic [1:0]                 n_rows;
    logic [1:0]                 n_cols;

    logic       m_valid_reg;
    out_item_t  m_item_reg;

    logic [WB-1:0]  cfg_width;
    logic [FH_BITS-1:0] cfg_height;
    logic       cfg_write;
    logic       accept;
    logic       all_in;
    logic       take_pixel;
    logic       take_drain;
    logic       start_shift;
    logic       rd_en;
    logic       in_col_last;
    logic       out_col_last;
    logic       out_row_last;
    logic       emerge;
    logic       last;
    logic       out_free;

    div_req_t                     div_req;
    logic                         div_start;
    logic                         div_done;
    logic signed [PIXEL_BITS-1:0] div_quotient;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        if (pwdata[FW_BITS-1:0] == '0) begin
            cfg_width = WB'(1);
        end else if (32'(pwdata[FW_BITS-1:0]) > MAX_WIDTH) begin
            cfg_width = WB'(MAX_WIDTH);
        end else begin
            cfg_width = WB'(pwdata[FW_BITS-1:0]);
        end
        if (pwdata[FH_BITS-1:0] == '0) begin
            cfg_height = FH_BITS'(1);
        end else begin
            cfg_height = pwdata[FH_BITS-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = 32'(width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(height_reg);
        endcase
    end

    // Position tracking. Every pixel is in once the row count reaches the height.
    assign all_in       = in_row_reg >= ROW_BITS'(height_reg);
    assign in_col_last  = (WB'(in_col_reg) + WB'(1)) == width_reg;
    assign out_col_last = (WB'(out_col_reg) + WB'(1)) == width_reg;
    assign out_row_last = out_row_reg == (height_reg - FH_BITS'(1));
    assign last         = out_row_last && out_col_last;
    // A result appears once one row and one pixel have gone in ahead of it.
    assign emerge       = (in_row_reg >= ROW_BITS'(2)) ||
                          ((in_row_reg == ROW_BITS'(1)) && (in_col_reg != '0));

    assign s_ready     = (state_reg == S_IDLE);
    assign accept      = s_valid && s_ready;
    assign take_pixel  = (s_item.cmd == CMD_PIXEL) && !all_in;
    assign take_drain  = (s_item.cmd == CMD_DRAIN) && all_in;
    assign start_shift = accept && (take_pixel || take_drain);
    assign rd_en       = start_shift || (state_reg == S_READ);
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start_shift) state_next = S_SHIFT;
            S_SHIFT: begin
                if (emerge) begin
                    state_next = S_ROWS;
                end else if (drain_reg && !retry_reg) begin
                    state_next = S_READ;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_READ:  state_next = S_SHIFT;
            S_ROWS:  state_next = S_TOTAL;
            S_TOTAL: state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_PUSH;
            S_PUSH:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            width_reg   <= WB'(RESET_WIDTH);
            height_reg  <= FH_BITS'(DEFAULT_HEIGHT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            retry_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                retry_reg <= 1'b0;
            end else if (state_reg == S_SHIFT && !emerge && drain_reg) begin
                retry_reg <= 1'b1;
            end
            if (cfg_write) begin
                unique case (paddr[2])
                    REG_FRAME_WIDTH:  width_reg  <= cfg_width;
                    REG_FRAME_HEIGHT: height_reg <= cfg_height;
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else if (state_reg == S_SHIFT) begin
                if (emerge && last) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else begin
                    if (in_col_last) begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + ROW_BITS'(1);
                    end else begin
                        in_col_reg <= in_col_reg + CB'(1);
                    end
                    if (emerge) begin
                        if (out_col_last) begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + FH_BITS'(1);
                        end else begin
                            out_col_reg <= out_col_reg + CB'(1);
                        end
                    end
                end
            end
        end
    end

    // Row stores: read at the current column, then the older row moves down.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= row_a_mem[in_col_reg];
            rd_b_reg <= row_b_mem[in_col_reg];
        end
        if (state_reg == S_SHIFT) begin
            row_a_mem[in_col_reg] <= x_reg;
            row_b_mem[in_col_reg] <= rd_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg     <= take_pixel ? s_item.pixel : '0;
            drain_reg <= take_drain;
        end
        if (state_reg == S_SHIFT) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd_b_reg;
            win_reg[1][2] <= rd_a_reg;
            win_reg[2][2] <= x_reg;
            if (emerge) begin
                top_reg    <= out_row_reg != '0;
                bottom_reg <= !out_row_last;
                left_reg   <= out_col_reg != '0;
                right_reg  <= !out_col_last;
                eof_reg    <= last;
            end
        end
        if (state_reg == S_ROWS) begin
            row_sum_reg <= row_sum;
        end
        if (state_reg == S_TOTAL) begin
            sum_reg <= SUM_BITS'(row_sum_reg[0]) + SUM_BITS'(row_sum_reg[1]) +
                       SUM_BITS'(row_sum_reg[2]);
        end
    end

    // Neighbors outside the frame drop out of both the sum and the count.
    always_comb begin
        row_on = {bottom_reg, 1'b1, top_reg};
        for (int i = 0; i < 3; i++) begin
            row_sum[i] = RS_BITS'(win_reg[i][1]);
            if (left_reg) begin
                row_sum[i] = row_sum[i] + RS_BITS'(win_reg[i][0]);
            end
            if (right_reg) begin
                row_sum[i] = row_sum[i] + RS_BITS'(win_reg[i][2]);
            end
            if (!row_on[i]) begin
                row_sum[i] = '0;
            end
        end
    end

    assign n_rows = 2'd1 + {1'b0, top_reg} + {1'b0, bottom_reg};
    assign n_cols = 2'd1 + {1'b0, left_reg} + {1'b0, right_reg};

    assign div_start       = (state_reg == S_START);
    assign div_req.sum     = sum_reg;
    assign div_req.divisor = DIVISOR_BITS'(n_rows) * DIVISOR_BITS'(n_cols);

    eabm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_PUSH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_PUSH && out_free) begin
            m_item_reg.mean_value   <= div_quotient;
            m_item_reg.end_of_frame <= eof_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_in_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (WB'(in_col_reg) < width_reg))
        else $error("input column ran past the frame width");

    a_out_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_row_reg < height_reg))
        else $error("result row ran past the frame height");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the wait state");

    a_divisor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (div_req.divisor != '0 && div_req.divisor <= DIVISOR_BITS'(9)))
        else $error("neighbor count out of range");

endmodule

// ----- dv/tb_edge_aware_box_mean_3x3.sv -----
`timescale 1ns / 100ps

module tb_edge_aware_box_mean_3x3;
    import eabm_pkg::*;

    localparam int MAX_W = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 1000000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_item = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_item;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    edge_aware_box_mean_3x3 u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Filter state as the block should hold it.
    int          row_recent [MAX_W];
    int          row_older [MAX_W];
    int          win [3][3];
    int unsigned in_col, in_row, out_col, out_row;
    int unsigned frame_w = DEFAULT_WIDTH;
    int unsigned frame_h = DEFAULT_HEIGHT;

    out_item_t   expected_means [$];
    int unsigned frames_closed;
    int unsigned effective_items;
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int unsigned cycles;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 100) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_means.size() == 0) begin
                report_mismatch($sformatf("unexpected result, mean %0d end_of_frame %0b",
                                          m_item.mean_value, m_item.end_of_frame));
            end else begin
                want = expected_means.pop_front();
                if (m_item.mean_value !== want.mean_value) begin
                    report_mismatch($sformatf("mean_value %0d, expected %0d",
                                              m_item.mean_value, want.mean_value));
                end
                if (m_item.end_of_frame !== want.end_of_frame) begin
                    report_mismatch($sformatf("end_of_frame %0b, expected %0b",
                                              m_item.end_of_frame, want.end_of_frame));
                end
            end
        end
    end

    function automatic void restart_positions();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void apply_register(input logic idx, input logic [31:0] data);
        int unsigned v;
        if (idx == REG_FRAME_WIDTH) begin
            v = 32'(data[FW_BITS-1:0]);
            if (v == 0) v = 1;
            if (v > MAX_W) v = MAX_W;
            frame_w = v;
            restart_positions();
        end else if (idx == REG_FRAME_HEIGHT) begin
            v = 32'(data[FH_BITS-1:0]);
            if (v == 0) v = 1;
            frame_h = v;
            restart_positions();
        end
    endfunction

    // Shifts one column into the window and reports whether a mean falls out.
    function automatic bit push_column(input int x, output out_item_t res);
        int          col_v [3];
        int unsigned k;
        longint      total;
        longint      mean;
        int          count;
        bit          last;
        col_v[0] = row_older[in_col];
        col_v[1] = row_recent[in_col];
        col_v[2] = x;
        row_older[in_col] = row_recent[in_col];
        row_recent[in_col] = x;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
            win[i][2] = col_v[i];
        end
        k = in_row * frame_w + in_col;
        if (in_col + 1 >= frame_w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col++;
        end
        if (k < frame_w + 1) return 1'b0;

        total = 0;
        count = 0;
        for (int i = 0; i < 3; i++) begin
            if (i == 0 && out_row == 0) continue;
            if (i == 2 && out_row + 1 >= frame_h) continue;
            for (int j = 0; j < 3; j++) begin
                if (j == 0 && out_col == 0) continue;
                if (j == 2 && out_col + 1 >= frame_w) continue;
                total += win[i][j];
                count++;
            end
        end
        mean = total / count;
        last = (out_row + 1 >= frame_h) && (out_col + 1 >= frame_w);
        res.mean_value = mean[PIXEL_BITS-1:0];
        res.end_of_frame = last;
        if (last) begin
            restart_positions();
            frames_closed++;
        end else if (out_col + 1 >= frame_w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
        return 1'b1;
    endfunction

    function automatic void advance_filter(input in_item_t it);
        out_item_t res;
        bit        all_in;
        bit        got;
        all_in = (in_row * frame_w + in_col) >= frame_w * frame_h;
        got = 1'b0;
        if (it.cmd == CMD_PIXEL) begin
            // A pixel after the frame's last one is dropped.
            if (!all_in) begin
                effective_items++;
                got = push_column(int'(it.pixel), res);
            end
        end else if (all_in) begin
            // A single-row frame needs a second blank column to release a mean.
            effective_items++;
            got = push_column(0, res);
            if (!got) got = push_column(0, res);
        end
        if (got) expected_means.push_back(res);
    endfunction

    task automatic send_item(input logic cmd, input logic signed [PIXEL_BITS-1:0] pix);
        in_item_t it;
        it.cmd = cmd;
        it.pixel = pix;
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        advance_filter(it);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apply_register(idx, data);
    endtask

    task automatic apb_read(input logic idx, output logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        wait_idle();
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
    endtask

    function automatic logic signed [PIXEL_BITS-1:0] random_pixel();
        case ($urandom_range(15))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return '1;
            default: return PIXEL_BITS'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Drains until the frame's last mean is out, now and then slipping in a stray pixel.
    task automatic drain_frame(input int late_pct);
        int unsigned closed_at;
        closed_at = frames_closed;
        while (frames_closed == closed_at) begin
            if ($urandom_range(99) < late_pct) send_item(CMD_PIXEL, random_pixel());
            send_item(CMD_DRAIN, '0);
        end
    endtask

    task automatic test_directed_cases(input int sp, input int rp);
        logic signed [PIXEL_BITS-1:0] two_row [6] =
            '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0002};
        logic signed [PIXEL_BITS-1:0] one_row [4] =
            '{16'sh8000, 16'sh0003, 16'shFFFE, 16'sh7FFF};
        send_idle_pct = sp;
        recv_idle_pct = rp;
        // The reset geometry is 1024 by 1024, so a lone pixel yields nothing.
        send_item(CMD_PIXEL, 16'sd5);
        // Zero in either register selects one pixel per row and one row.
        set_frame(0, 0);
        send_item(CMD_DRAIN, '0);
        send_item(CMD_PIXEL, 16'sh7FFF);
        send_item(CMD_PIXEL, 16'sh8000);
        send_item(CMD_DRAIN, '0);
        send_item(CMD_PIXEL, 16'sh8000);
        send_item(CMD_DRAIN, '0);
        set_frame(3, 2);
        foreach (two_row[i]) send_item(CMD_PIXEL, two_row[i]);
        drain_frame(0);
        set_frame(4, 1);
        foreach (one_row[i]) send_item(CMD_PIXEL, one_row[i]);
        drain_frame(0);
    endtask

    task automatic test_random_frames(input int sp, input int rp, input int unsigned target);
        int unsigned start, w, h, n_pix, cut;
        bit          need_cfg;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        start = effective_items;
        need_cfg = 1'b1;
        while (effective_items - start < target) begin
            if (need_cfg || $urandom_range(2) == 0) begin
                w = ($urandom_range(4) == 0) ? $urandom_range(32, 9) : $urandom_range(8, 0);
                h = ($urandom_range(4) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 0);
                set_frame(w, h);
            end
            n_pix = frame_w * frame_h;
            // Some frames are cut short; the next register write abandons them.
            cut = ($urandom_range(9) == 0) ? $urandom_range(n_pix - 1, 0) : n_pix;
            need_cfg = (cut != n_pix);
            repeat (cut) begin
                if ($urandom_range(29) == 0) send_item(CMD_DRAIN, '0);
                send_item(CMD_PIXEL, random_pixel());
            end
            if (!need_cfg) drain_frame(5);
        end
    endtask

    task automatic test_tall_frame(input int sp, input int rp);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        set_frame(1, 65535);
        repeat (60) send_item(CMD_PIXEL, random_pixel());
        // The write restarts the frame, so the means still pending never come out.
        set_frame(2, 2);
        repeat (4) send_item(CMD_PIXEL, random_pixel());
        drain_frame(0);
    endtask

    task automatic test_wide_frame(input int sp, input int rp);
        logic [31:0] rd_width;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        // A width above the line store size is clamped to it.
        set_frame(2047, 1);
        apb_read(REG_FRAME_WIDTH, rd_width);
        if (rd_width !== 32'(frame_w)) begin
            report_mismatch($sformatf("frame_width reads %0d, expected %0d",
                                      rd_width, frame_w));
        end
        set_frame(64, 2);
        repeat (128) send_item(CMD_PIXEL, random_pixel());
        drain_frame(0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_cases(37, 79);
        test_random_frames(37, 79, 230);
        test_tall_frame(37, 79);
        test_random_frames(79, 37, 230);
        test_wide_frame(0, 0);
        test_random_frames(0, 0, 240);
        wait_idle();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
